>>> design/sjf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared types, codes and helpers for the spring joint force block.
// ----------------------------------------------------------------------------
package sjf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_AW        = 3;

  typedef enum logic [1:0] {
    FUNC_STORE = 2'd0,
    FUNC_FORCE = 2'd1,
    FUNC_REST  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  localparam logic [CFG_AW-1:0] REG_I_OFF_X = 3'd0;
  localparam logic [CFG_AW-1:0] REG_I_OFF_Y = 3'd1;
  localparam logic [CFG_AW-1:0] REG_I_OFF_Z = 3'd2;
  localparam logic [CFG_AW-1:0] REG_J_OFF_X = 3'd3;
  localparam logic [CFG_AW-1:0] REG_J_OFF_Y = 3'd4;
  localparam logic [CFG_AW-1:0] REG_J_OFF_Z = 3'd5;
  localparam logic [CFG_AW-1:0] REG_STIFF   = 3'd6;

  localparam logic [32:0]        MAX_FORCE = 33'h1_FFFF_FFFF;
  localparam logic signed [15:0] QUAT_ONE  = 16'sd16384;
  localparam logic [33:0]        LEN_MAX   = 34'h0_7FFF_FFFF;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    if (x > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < 48'shFFFF_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

>>> design/spring_joint_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_joint_force
// Linear spring force on body j from a joint between two rigid bodies, in
// fixed point, on one shared multiplier with bit-serial root and divide.
//
// channel   dir  fields
// s_axis    in   tuser: func; tdata: pos_x, pos_y, pos_z, quat_w/x/y/z
// m_axis    out  tuser: degenerate; tdata: force_x/y/z, stretch
// cfg       in   write enable, register index, 32-bit data
//
// func 0 and func 3 are handled in the idle state. func 1 runs 45 multiplies on
// the shared 34x34 multiplier, a 32-step square root and three 31-step divides
// (the divides and force multiplies are skipped when the points coincide).
// Reset puts the stored pose at the origin with identity rotation.
// s_axis is not ready while an item is in work; a finished result waits in
// the output register, and a new item may start meanwhile.
// ----------------------------------------------------------------------------
module spring_joint_force #(
  parameter int FRAC_BITS = sjf_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sjf_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [31:0]               cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
  input  logic [159:0]              s_axis_tdata,
  // func
  input  logic [1:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // force_x, force_y, force_z, stretch
  output logic [127:0]              m_axis_tdata,
  // degenerate
  output logic [0:0]                m_axis_tuser
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_QMUL, ST_QSTO, ST_MLD, ST_MMUL, ST_MACC, ST_MFIN, ST_DIFF,
    ST_SMUL, ST_SACC, ST_ROOT, ST_LEN, ST_STR, ST_KMUL, ST_KFIN, ST_DINI,
    ST_DIV, ST_FMUL, ST_FFIN, ST_OUT
  } state_e;

  state_e state_q;

  logic signed [31:0] ioff_q [3];
  logic signed [31:0] joff_q [3];
  logic [31:0]        stiff_q;
  logic signed [31:0] spos_q [3];
  logic signed [15:0] srot_q [4];
  logic signed [31:0] rest_q;
  sjf_pkg::func_e     func_q;
  logic signed [31:0] ipos_q [3];
  logic signed [15:0] irot_q [4];

  logic               side_q;
  logic [3:0]         cnt_q;
  logic [1:0]         row_q, col_q;
  logic signed [31:0] qp_q [10];
  logic signed [29:0] mreg_q;
  logic signed [67:0] prod_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] pi_q [3];
  logic signed [31:0] pj_q [3];
  logic [32:0]        a_q [3];
  logic [2:0]         dneg_q;
  logic               shift_q, degen_q;
  logic [63:0]        sum_q;
  logic [32:0]        rem_q;
  logic [31:0]        root_q;
  logic [4:0]         sc_q;
  logic [33:0]        len_q;
  logic signed [31:0] s_q;
  logic [31:0]        smag_q;
  logic [32:0]        fm_q;
  logic [33:0]        drem_q;
  logic [30:0]        quo_q;
  logic [4:0]         dc_q;
  logic signed [31:0] force_q [3];
  logic               mv_q;
  logic [127:0]       odata_q;
  logic               odeg_q;

  sjf_pkg::func_e     in_func;
  logic signed [31:0] in_pos [3];
  logic signed [15:0] in_rot [4];
  logic signed [15:0] q_cur [4];
  logic signed [31:0] pos_cur [3];
  logic signed [31:0] off_cur [3];
  logic [1:0]         qa_idx, qb_idx;
  logic signed [33:0] qx [10];
  logic signed [33:0] m_ent;
  logic signed [29:0] m_rnd;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [63:0] acc_rs;
  logic signed [31:0] pt_sat;
  logic signed [32:0] d_v [3];
  logic [32:0]        a_d [3];
  logic [2:0]         dneg_d;
  logic [32:0]        h_v;
  logic [34:0]        rem_t, trial;
  logic [33:0]        len_d;
  logic signed [47:0] sd;
  logic signed [31:0] s_d;
  logic [63:0]        fmr;
  logic [32:0]        fm_d;
  logic [34:0]        dvt;
  logic               dge;
  logic               neg;
  logic signed [47:0] fp;
  logic signed [31:0] f_sat;

  assign in_func = sjf_pkg::func_e'(s_axis_tuser);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_pos[k]  = s_axis_tdata[32*k +: 32];
      pos_cur[k] = side_q ? ipos_q[k] : spos_q[k];
      off_cur[k] = side_q ? joff_q[k] : ioff_q[k];
    end
    for (int k = 0; k < 4; k++) begin
      in_rot[k] = s_axis_tdata[96 + 16*k +: 16];
      q_cur[k]  = side_q ? irot_q[k] : srot_q[k];
    end
    for (int k = 0; k < 10; k++) begin
      qx[k] = 34'(qp_q[k]);
    end
  end

  // product order: ww xx yy zz xy xz yz wx wy wz
  always_comb begin
    unique case (cnt_q)
      4'd0:    begin qa_idx = 2'd0; qb_idx = 2'd0; end
      4'd1:    begin qa_idx = 2'd1; qb_idx = 2'd1; end
      4'd2:    begin qa_idx = 2'd2; qb_idx = 2'd2; end
      4'd3:    begin qa_idx = 2'd3; qb_idx = 2'd3; end
      4'd4:    begin qa_idx = 2'd1; qb_idx = 2'd2; end
      4'd5:    begin qa_idx = 2'd1; qb_idx = 2'd3; end
      4'd6:    begin qa_idx = 2'd2; qb_idx = 2'd3; end
      4'd7:    begin qa_idx = 2'd0; qb_idx = 2'd1; end
      4'd8:    begin qa_idx = 2'd0; qb_idx = 2'd2; end
      4'd9:    begin qa_idx = 2'd0; qb_idx = 2'd3; end
      default: begin qa_idx = 2'd0; qb_idx = 2'd0; end
    endcase
  end

  // rotation matrix entry in Q.28
  always_comb begin
    unique case ({row_q, col_q})
      4'b0000: m_ent = qx[0] + qx[1] - qx[2] - qx[3];
      4'b0001: m_ent = (qx[4] - qx[9]) <<< 1;
      4'b0010: m_ent = (qx[5] + qx[8]) <<< 1;
      4'b0100: m_ent = (qx[4] + qx[9]) <<< 1;
      4'b0101: m_ent = qx[0] - qx[1] + qx[2] - qx[3];
      4'b0110: m_ent = (qx[6] - qx[7]) <<< 1;
      4'b1000: m_ent = (qx[5] - qx[8]) <<< 1;
      4'b1001: m_ent = (qx[6] + qx[7]) <<< 1;
      4'b1010: m_ent = qx[0] - qx[1] - qx[2] + qx[3];
      default: m_ent = '0;
    endcase
  end

  assign m_rnd = 30'((m_ent + 34'sd8) >>> 4);

  always_comb begin
    h_v = shift_q ? {1'b0, a_q[cnt_q[1:0]][32:1]} : a_q[cnt_q[1:0]];
    unique case (state_q)
      ST_QMUL: begin mul_a = 34'(q_cur[qa_idx]); mul_b = 34'(q_cur[qb_idx]); end
      ST_MMUL: begin mul_a = 34'(mreg_q); mul_b = 34'(off_cur[col_q]); end
      ST_SMUL: begin mul_a = {1'b0, h_v}; mul_b = {1'b0, h_v}; end
      ST_KMUL: begin mul_a = {2'b0, stiff_q}; mul_b = {2'b0, smag_q}; end
      ST_FMUL: begin mul_a = {1'b0, fm_q}; mul_b = {3'b0, quo_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign acc_rs = (acc_q + 64'sd8388608) >>> 24;
  assign pt_sat = sjf_pkg::sat32(48'(acc_rs) + 48'(pos_cur[row_q]));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_v[k]    = 33'(pj_q[k]) - 33'(pi_q[k]);
      dneg_d[k] = d_v[k][32];
      a_d[k]    = d_v[k][32] ? 33'(-d_v[k]) : d_v[k];
    end
  end

  assign rem_t = {rem_q, sum_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};
  assign len_d = shift_q ? {1'b0, root_q, 1'b0} : {2'b0, root_q};

  assign sd  = $signed({14'd0, len_q}) - 48'(rest_q);
  assign s_d = sjf_pkg::sat32(sd);

  assign fmr  = prod_q[63:0] >> FRAC_BITS;
  assign fm_d = (fmr > 64'(sjf_pkg::MAX_FORCE)) ? sjf_pkg::MAX_FORCE : fmr[32:0];

  assign dvt = {drem_q, (dc_q == 5'd30) ? a_q[cnt_q[1:0]][0] : 1'b0};
  assign dge = dvt >= {1'b0, len_q};

  assign neg = ((s_q > 0) && !dneg_q[cnt_q[1:0]] && (a_q[cnt_q[1:0]] != '0)) ||
               ((s_q < 0) && dneg_q[cnt_q[1:0]]);
  assign fp    = $signed({14'd0, prod_q[63:30]});
  assign f_sat = sjf_pkg::sat32(neg ? -fp : fp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int k = 0; k < 3; k++) begin
        ioff_q[k] <= '0; joff_q[k] <= '0; spos_q[k] <= '0;
        ipos_q[k] <= '0; pi_q[k] <= '0; pj_q[k] <= '0;
        a_q[k] <= '0; force_q[k] <= '0;
      end
      for (int k = 0; k < 4; k++) begin
        srot_q[k] <= (k == 0) ? sjf_pkg::QUAT_ONE : 16'sd0;
        irot_q[k] <= '0;
      end
      for (int k = 0; k < 10; k++) qp_q[k] <= '0;
      stiff_q <= '0; rest_q <= '0; func_q <= sjf_pkg::FUNC_NOP;
      side_q <= 1'b0; cnt_q <= '0; row_q <= '0; col_q <= '0;
      mreg_q <= '0; prod_q <= '0; acc_q <= '0; dneg_q <= '0;
      shift_q <= 1'b0; degen_q <= 1'b0; sum_q <= '0; rem_q <= '0;
      root_q <= '0; sc_q <= '0; len_q <= '0; s_q <= '0; smag_q <= '0;
      fm_q <= '0; drem_q <= '0; quo_q <= '0; dc_q <= '0;
      mv_q <= 1'b0; odata_q <= '0; odeg_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          sjf_pkg::REG_I_OFF_X: ioff_q[0] <= cfg_wdata_i;
          sjf_pkg::REG_I_OFF_Y: ioff_q[1] <= cfg_wdata_i;
          sjf_pkg::REG_I_OFF_Z: ioff_q[2] <= cfg_wdata_i;
          sjf_pkg::REG_J_OFF_X: joff_q[0] <= cfg_wdata_i;
          sjf_pkg::REG_J_OFF_Y: joff_q[1] <= cfg_wdata_i;
          sjf_pkg::REG_J_OFF_Z: joff_q[2] <= cfg_wdata_i;
          sjf_pkg::REG_STIFF:   stiff_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (mv_q && m_axis_tready && (state_q != ST_OUT)) mv_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            unique case (in_func) inside
              sjf_pkg::FUNC_STORE: begin
                for (int k = 0; k < 3; k++) spos_q[k] <= in_pos[k];
                for (int k = 0; k < 4; k++) srot_q[k] <= in_rot[k];
              end
              sjf_pkg::FUNC_FORCE, sjf_pkg::FUNC_REST: begin
                for (int k = 0; k < 3; k++) ipos_q[k] <= in_pos[k];
                for (int k = 0; k < 4; k++) irot_q[k] <= in_rot[k];
                func_q  <= in_func;
                side_q  <= 1'b0;
                cnt_q   <= '0;
                row_q   <= '0;
                col_q   <= '0;
                acc_q   <= '0;
                state_q <= ST_QMUL;
              end
              default: ;
            endcase
          end
        end
        ST_QMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_QSTO;
        end
        ST_QSTO: begin
          qp_q[cnt_q] <= prod_q[31:0];
          if (cnt_q == 4'd9) begin
            row_q   <= '0;
            col_q   <= '0;
            state_q <= ST_MLD;
          end else begin
            cnt_q   <= cnt_q + 4'd1;
            state_q <= ST_QMUL;
          end
        end
        ST_MLD: begin
          mreg_q  <= m_rnd;
          state_q <= ST_MMUL;
        end
        ST_MMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_MACC;
        end
        ST_MACC: begin
          acc_q <= acc_q + prod_q[63:0];
          if (col_q == 2'd2) begin
            state_q <= ST_MFIN;
          end else begin
            col_q   <= col_q + 2'd1;
            state_q <= ST_MLD;
          end
        end
        ST_MFIN: begin
          acc_q <= '0;
          col_q <= '0;
          if (side_q) pj_q[row_q] <= pt_sat;
          else pi_q[row_q] <= pt_sat;
          if (row_q == 2'd2) begin
            row_q <= '0;
            if (!side_q) begin
              side_q  <= 1'b1;
              cnt_q   <= '0;
              state_q <= ST_QMUL;
            end else begin
              state_q <= ST_DIFF;
            end
          end else begin
            row_q   <= row_q + 2'd1;
            state_q <= ST_MLD;
          end
        end
        ST_DIFF: begin
          for (int k = 0; k < 3; k++) a_q[k] <= a_d[k];
          dneg_q  <= dneg_d;
          shift_q <= a_d[0][32] | a_d[0][31] | a_d[1][32] | a_d[1][31] |
                     a_d[2][32] | a_d[2][31];
          degen_q <= (a_d[0] | a_d[1] | a_d[2]) == '0;
          sum_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_SMUL;
        end
        ST_SMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_SACC;
        end
        ST_SACC: begin
          sum_q <= sum_q + prod_q[63:0];
          if (cnt_q == 4'd2) begin
            rem_q   <= '0;
            root_q  <= '0;
            sc_q    <= 5'd31;
            state_q <= ST_ROOT;
          end else begin
            cnt_q   <= cnt_q + 4'd1;
            state_q <= ST_SMUL;
          end
        end
        ST_ROOT: begin
          sum_q <= sum_q << 2;
          if (rem_t >= trial) begin
            rem_q  <= 33'(rem_t - trial);
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q  <= rem_t[32:0];
            root_q <= {root_q[30:0], 1'b0};
          end
          if (sc_q == '0) state_q <= ST_LEN;
          else sc_q <= sc_q - 5'd1;
        end
        ST_LEN: begin
          len_q <= len_d;
          if (func_q == sjf_pkg::FUNC_REST) begin
            rest_q  <= (len_d > sjf_pkg::LEN_MAX) ? 32'sh7FFF_FFFF : len_d[31:0];
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_STR;
          end
        end
        ST_STR: begin
          s_q     <= s_d;
          smag_q  <= s_d[31] ? 32'(-s_d) : s_d;
          state_q <= ST_KMUL;
        end
        ST_KMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_KFIN;
        end
        ST_KFIN: begin
          fm_q  <= fm_d;
          cnt_q <= '0;
          if (degen_q) begin
            for (int k = 0; k < 3; k++) force_q[k] <= '0;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_DINI;
          end
        end
        ST_DINI: begin
          drem_q  <= {2'b0, a_q[cnt_q[1:0]][32:1]};
          quo_q   <= '0;
          dc_q    <= 5'd30;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          drem_q <= dge ? 34'(dvt - {1'b0, len_q}) : dvt[33:0];
          quo_q  <= {quo_q[29:0], dge};
          if (dc_q == '0) state_q <= ST_FMUL;
          else dc_q <= dc_q - 5'd1;
        end
        ST_FMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_FFIN;
        end
        ST_FFIN: begin
          force_q[cnt_q[1:0]] <= f_sat;
          if (cnt_q == 4'd2) begin
            state_q <= ST_OUT;
          end else begin
            cnt_q   <= cnt_q + 4'd1;
            state_q <= ST_DINI;
          end
        end
        ST_OUT: begin
          if (!mv_q || m_axis_tready) begin
            odata_q <= {s_q, force_q[2], force_q[1], force_q[0]};
            odeg_q  <= degen_q;
            mv_q    <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = odeg_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[95:0] == 96'd0))
    else $error("degenerate beat carries nonzero force");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (drem_q < len_q))
    else $error("divider remainder not below divisor");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready &&
     ((sjf_pkg::func_e'(s_axis_tuser) == sjf_pkg::FUNC_FORCE) ||
      (sjf_pkg::func_e'(s_axis_tuser) == sjf_pkg::FUNC_REST))) |=> !s_axis_tready)
    else $error("not busy after a compute beat");

  a_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready &&
     (sjf_pkg::func_e'(s_axis_tuser) == sjf_pkg::FUNC_STORE))
    |=> (spos_q[0] == $past(s_axis_tdata[31:0])))
    else $error("stored pose not taken from beat");

  a_nodegen_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FFIN) |-> !degen_q)
    else $error("divide run on coincident points");

endmodule
